>>> rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Used by mexp_mulmod and modular_exponentiation; depends on nothing.
package mexp_pkg;

  // Width of every operand, the modulus and the result.
  localparam int unsigned FIELD_W = 31;
  // Counter width for one pass over the operand bits.
  localparam int unsigned CNT_W = $clog2(FIELD_W);
  // Configuration address width and register indexes.
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_MODULUS = 1'b0;
  localparam logic [FIELD_W-1:0] MODULUS_RESET = FIELD_W'(2);

  typedef logic [FIELD_W-1:0] field_t;

  // Multiply request: product a * b reduced by the modulus.
  typedef struct packed {
    logic   start;
    field_t a;
    field_t b;
  } mm_req_t;

  // Multiply response: done is high in the last cycle, with the product.
  typedef struct packed {
    logic   done;
    field_t prod;
  } mm_rsp_t;

endpackage

>>> rtl/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: one bit of operand a per cycle.
// Depends on mexp_pkg for widths and the request and response structs.
module mexp_mulmod (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mexp_pkg::mm_req_t        req_i,
  input  mexp_pkg::field_t         modulus_i,
  output mexp_pkg::mm_rsp_t        rsp_o
);

  mexp_pkg::field_t a_q, a_d;
  mexp_pkg::field_t b_q;
  mexp_pkg::field_t n_q;
  mexp_pkg::field_t r_q, r_d;
  logic [mexp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;

  logic [mexp_pkg::FIELD_W+1:0] sum;
  logic [mexp_pkg::FIELD_W+1:0] n1;
  logic [mexp_pkg::FIELD_W+1:0] n2;
  logic [mexp_pkg::FIELD_W+1:0] addend;
  logic [mexp_pkg::FIELD_W+1:0] reduced;

  // One step: double the partial product, add b when the current bit of a
  // is set, then take off the modulus once or twice so it stays below n.
  always_comb begin
    addend  = a_q[mexp_pkg::FIELD_W-1] ? {2'b00, b_q} : '0;
    sum     = {1'b0, r_q, 1'b0} + addend;
    n1      = {2'b00, n_q};
    n2      = {1'b0, n_q, 1'b0};
    if (sum >= n2) begin
      reduced = sum - n2;
    end else if (sum >= n1) begin
      reduced = sum - n1;
    end else begin
      reduced = sum;
    end
  end

  // Next-state logic for the bit counter and the operand shift.
  always_comb begin
    a_d    = a_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (req_i.start) begin
      a_d    = req_i.a;
      r_d    = '0;
      cnt_d  = mexp_pkg::CNT_W'(mexp_pkg::FIELD_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      a_d   = {a_q[mexp_pkg::FIELD_W-2:0], 1'b0};
      r_d   = reduced[mexp_pkg::FIELD_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  // Operand and partial product registers.
  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    r_q <= r_d;
    if (req_i.start) begin
      b_q <= req_i.b;
      n_q <= modulus_i;
    end
  end

  // The product is ready in the last step, straight from the reduction.
  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.prod = reduced[mexp_pkg::FIELD_W-1:0];

endmodule

>>> rtl/modular_exponentiation.sv
// Modular exponentiation: power_mod = base ** exponent mod modulus, by
// left-to-right square and multiply over all 31 exponent bits. Every
// modular product runs through one bit-serial multiplier; the first one
// reduces the base. busy is high from the cycle after start is taken until
// the result strobe has passed. The result is shown for exactly one cycle
// with power_mod_valid_o and is not held, so the receiver must take
// it then. A modulus below two gives zero at once. Write modulus only
// while busy is low. Depends on mexp_pkg and mexp_mulmod.
module modular_exponentiation (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mexp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Request channel.
  input  logic                          start,
  output logic                          busy,
  input  logic [mexp_pkg::FIELD_W-1:0]  base_i,
  input  logic [mexp_pkg::FIELD_W-1:0]  exponent_i,
  // Result channel.
  output logic                          power_mod_valid_o,
  output logic [mexp_pkg::FIELD_W-1:0]  power_mod_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_SQ   = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0] state_q, state_d;
  mexp_pkg::field_t modulus_q;
  mexp_pkg::field_t base_q, base_d;
  mexp_pkg::field_t exp_q, exp_d;
  mexp_pkg::field_t res_q, res_d;
  logic [mexp_pkg::CNT_W-1:0] cnt_q, cnt_d;

  mexp_pkg::mm_req_t mm_req;
  mexp_pkg::mm_rsp_t mm_rsp;
  logic accept;
  logic cfg_write;
  logic mod_small;

  // Configuration register access.
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == mexp_pkg::REG_MODULUS) ? {1'b0, modulus_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= mexp_pkg::MODULUS_RESET;
    end else if (cfg_write && (paddr[2] == mexp_pkg::REG_MODULUS)) begin
      modulus_q <= pwdata[mexp_pkg::FIELD_W-1:0];
    end
  end

  assign accept    = start && !busy;
  assign mod_small = (modulus_q < mexp_pkg::FIELD_W'(2));

  // Sequencer: reduce the base, then per exponent bit a square and, for a
  // set bit, a multiply by the base. Each finished product but the last starts the next.
  always_comb begin
    state_d  = state_q;
    base_d   = base_q;
    exp_d    = exp_q;
    res_d    = res_q;
    cnt_d    = cnt_q;
    mm_req   = '0;
    unique case (state_q) inside
      ST_IDLE: begin
        if (start) begin
          exp_d = exponent_i;
          cnt_d = mexp_pkg::CNT_W'(mexp_pkg::FIELD_W - 1);
          if (mod_small) begin
            res_d   = '0;
            state_d = ST_OUT;
          end else begin
            mm_req.start = 1'b1;
            mm_req.a     = base_i;
            mm_req.b     = mexp_pkg::FIELD_W'(1);
            state_d      = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mm_rsp.done) begin
          base_d       = mm_rsp.prod;
          mm_req.start = 1'b1;
          mm_req.a     = mexp_pkg::FIELD_W'(1);
          mm_req.b     = mexp_pkg::FIELD_W'(1);
          state_d      = ST_SQ;
        end
      end
      ST_SQ, ST_MUL: begin
        if (mm_rsp.done) begin
          if ((state_q == ST_SQ) && exp_q[mexp_pkg::FIELD_W-1]) begin
            mm_req.start = 1'b1;
            mm_req.a     = mm_rsp.prod;
            mm_req.b     = base_q;
            state_d      = ST_MUL;
          end else if (cnt_q == '0) begin
            res_d   = mm_rsp.prod;
            state_d = ST_OUT;
          end else begin
            exp_d        = {exp_q[mexp_pkg::FIELD_W-2:0], 1'b0};
            cnt_d        = cnt_q - 1'b1;
            mm_req.start = 1'b1;
            mm_req.a     = mm_rsp.prod;
            mm_req.b     = mm_rsp.prod;
            state_d      = ST_SQ;
          end
        end
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    res_q  <= res_d;
  end

  mexp_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mm_req),
    .modulus_i (modulus_q),
    .rsp_o     (mm_rsp)
  );

  assign busy              = (state_q != ST_IDLE);
  assign power_mod_valid_o = (state_q == ST_OUT);
  assign power_mod_o       = res_q;

  // A taken request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block not busy after a request was taken");

  // The result strobe is followed by an idle block.
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    power_mod_valid_o |=> !busy && !power_mod_valid_o)
    else $error("block still busy after the result strobe");

  // The multiplier only finishes while a product is awaited.
  a_mm_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp.done |-> (state_q == ST_RED) || (state_q == ST_SQ) || (state_q == ST_MUL))
    else $error("multiplier finished outside a multiply step");

endmodule

>>> test/modular_exponentiation_test.sv
// Self-checking testbench for modular_exponentiation: directed and random requests
// with modulus writes over the APB port, each result checked against a local model.
// Depends on mexp_pkg and the modular_exponentiation RTL.
module modular_exponentiation_test;

  localparam int unsigned CLK_HALF = 4;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 2000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [mexp_pkg::ADDR_W-1:0] MODULUS_ADDR =
    mexp_pkg::ADDR_W'(4 * mexp_pkg::REG_MODULUS);
  localparam logic [mexp_pkg::ADDR_W-1:0] SPARE_ADDR = mexp_pkg::ADDR_W'(4);
  localparam mexp_pkg::field_t FIELD_MAX = '1;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [mexp_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  mexp_pkg::field_t base_i;
  mexp_pkg::field_t exponent_i;
  logic        power_mod_valid_o;
  mexp_pkg::field_t power_mod_o;

  // Modulus as the block should hold it, and the results still owed by it.
  mexp_pkg::field_t modulus_model;
  mexp_pkg::field_t expected_powers[$];
  int unsigned failure_count;

  modular_exponentiation u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .start             (start),
    .busy              (busy),
    .base_i            (base_i),
    .exponent_i        (exponent_i),
    .power_mod_valid_o (power_mod_valid_o),
    .power_mod_o       (power_mod_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #(CLK_HALF) clk_i = ~clk_i;

  // Left-to-right square and multiply, reducing after every product.
  function automatic mexp_pkg::field_t modexp_expected(mexp_pkg::field_t b,
                                                       mexp_pkg::field_t e,
                                                       mexp_pkg::field_t n);
    longint unsigned acc;
    longint unsigned base_red;
    longint unsigned n_wide;
    int bit_idx;
    if (n < 2) begin
      return '0;
    end
    n_wide = n;
    acc = 1;
    base_red = b % n_wide;
    for (bit_idx = mexp_pkg::FIELD_W - 1; bit_idx >= 0; bit_idx--) begin
      acc = (acc * acc) % n_wide;
      if (e[bit_idx]) begin
        acc = (acc * base_red) % n_wide;
      end
    end
    return mexp_pkg::field_t'(acc);
  endfunction

  // Counts a failure; only the first few are printed.
  task automatic note_failure(input string msg);
    failure_count++;
    if (failure_count <= REPORT_LIMIT) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
  endtask

  // Records each accepted request and checks each result strobe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        expected_powers.push_back(modexp_expected(base_i, exponent_i, modulus_model));
      end
      if (power_mod_valid_o) begin
        if (expected_powers.size() == 0) begin
          note_failure($sformatf("result %0d with no request outstanding", power_mod_o));
        end else begin
          if (power_mod_o !== expected_powers[0]) begin
            note_failure($sformatf("power_mod expected %0d, got %0d",
                                   expected_powers[0], power_mod_o));
          end
          void'(expected_powers.pop_front());
        end
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no transfer at all.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || power_mod_valid_o || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("modular_exponentiation verification failed");
    $finish;
  end

  // Presents one request after a gap and returns at the edge that takes it.
  task automatic issue_power_request(input mexp_pkg::field_t b, input mexp_pkg::field_t e,
                                     input int unsigned gap);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start      <= 1'b1;
    base_i     <= b;
    exponent_i <= e;
    do begin
      @(posedge clk_i);
    end while (busy);
  endtask

  // Drops start and waits until every result is in and the block is idle.
  task automatic wait_until_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_powers.size() != 0 || busy) begin
      @(negedge clk_i);
    end
  endtask

  // One APB transfer: setup cycle, then access cycle until pready.
  task automatic apb_transfer(input logic wr, input logic [mexp_pkg::ADDR_W-1:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    rdata = prdata;
    if (wr && addr == MODULUS_ADDR) begin
      modulus_model = wdata[mexp_pkg::FIELD_W-1:0];
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes a register while idle and reads the modulus back.
  task automatic write_register(input logic [mexp_pkg::ADDR_W-1:0] addr,
                                input logic [31:0] value);
    logic [31:0] rdata;
    wait_until_idle();
    apb_transfer(1'b1, addr, value, rdata);
    apb_transfer(1'b0, MODULUS_ADDR, '0, rdata);
    if (rdata[mexp_pkg::FIELD_W-1:0] !== modulus_model) begin
      note_failure($sformatf("modulus read back expected %0d, got %0d",
                             modulus_model, rdata[mexp_pkg::FIELD_W-1:0]));
    end
  endtask

  // The modulus left by reset is two.
  task automatic test_reset_modulus();
    issue_power_request(mexp_pkg::field_t'(3), mexp_pkg::field_t'(5), 0);
    issue_power_request(mexp_pkg::field_t'(0), mexp_pkg::field_t'(0), 2);
    issue_power_request(mexp_pkg::field_t'(4), mexp_pkg::field_t'(7), 0);
  endtask

  // Field extremes under the largest modulus.
  task automatic test_field_extremes();
    write_register(MODULUS_ADDR, {1'b0, FIELD_MAX});
    issue_power_request(FIELD_MAX, FIELD_MAX, 0);
    issue_power_request(mexp_pkg::field_t'(0), mexp_pkg::field_t'(0), 0);
    issue_power_request(mexp_pkg::field_t'(0), mexp_pkg::field_t'(5), 3);
    issue_power_request(FIELD_MAX, mexp_pkg::field_t'(1), 0);
    issue_power_request(FIELD_MAX - mexp_pkg::field_t'(1), FIELD_MAX, 1);
    issue_power_request(mexp_pkg::field_t'(2), mexp_pkg::field_t'(0), 0);
  endtask

  // A modulus of zero or one answers zero for everything.
  task automatic test_degenerate_modulus();
    write_register(MODULUS_ADDR, 32'd0);
    issue_power_request(mexp_pkg::field_t'(7), mexp_pkg::field_t'(0), 0);
    issue_power_request(FIELD_MAX, FIELD_MAX, 0);
    write_register(MODULUS_ADDR, 32'd1);
    issue_power_request(mexp_pkg::field_t'(0), mexp_pkg::field_t'(0), 1);
    issue_power_request(mexp_pkg::field_t'(12345), mexp_pkg::field_t'(678), 0);
  endtask

  // The top data bit is dropped and writes to other addresses are ignored.
  task automatic test_register_decode();
    write_register(MODULUS_ADDR, 32'h8000_0003);
    issue_power_request(mexp_pkg::field_t'(2), mexp_pkg::field_t'(5), 0);
    issue_power_request(mexp_pkg::field_t'(5), FIELD_MAX, 0);
    write_register(SPARE_ADDR, 32'h0000_0005);
    issue_power_request(mexp_pkg::field_t'(2), mexp_pkg::field_t'(3), 0);
  endtask

  // A base at or above the modulus is reduced first.
  task automatic test_reduced_base();
    write_register(MODULUS_ADDR, 32'd1000);
    issue_power_request(mexp_pkg::field_t'(1000), mexp_pkg::field_t'(3), 0);
    issue_power_request(mexp_pkg::field_t'(123456), mexp_pkg::field_t'(77), 2);
    issue_power_request(FIELD_MAX, mexp_pkg::field_t'(65537), 0);
  endtask

  // Random requests under one modulus; bursts leave no gap between requests.
  task automatic test_random_phase(input int unsigned count, input logic [31:0] modulus,
                                   input bit burst);
    mexp_pkg::field_t b;
    mexp_pkg::field_t e;
    int unsigned gap;
    write_register(MODULUS_ADDR, modulus);
    repeat (count) begin
      case ($urandom_range(0, 7))
        0: b = '0;
        1: b = FIELD_MAX;
        2: b = (modulus_model != 0) ? mexp_pkg::field_t'($urandom % modulus_model) : '0;
        3: b = modulus_model - mexp_pkg::field_t'($urandom_range(0, 1));
        default: b = mexp_pkg::field_t'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0: e = mexp_pkg::field_t'($urandom_range(0, 3));
        1: e = FIELD_MAX;
        2: e = mexp_pkg::field_t'(1) << $urandom_range(0, mexp_pkg::FIELD_W - 1);
        default: e = mexp_pkg::field_t'($urandom);
      endcase
      gap = burst ? 0 : $urandom_range(0, 10);
      issue_power_request(b, e, gap);
    end
  endtask

  // Test sequence.
  initial begin
    failure_count = 0;
    modulus_model = mexp_pkg::MODULUS_RESET;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    start      = 1'b0;
    base_i     = '0;
    exponent_i = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_modulus();
    test_field_extremes();
    test_degenerate_modulus();
    test_register_decode();
    test_reduced_base();
    test_random_phase(44, $urandom_range(2, 32'h7fff_ffff), 1'b0);
    test_random_phase(44, $urandom_range(2, 64), 1'b1);
    test_random_phase(44, {1'b0, FIELD_MAX}, 1'b0);
    test_random_phase(44, $urandom_range(2, 65535), 1'b0);
    test_random_phase(8, $urandom_range(0, 1), 1'b0);
    test_random_phase(44, 32'h4000_0000 | ($urandom & 32'h3fff_ffff), 1'b1);
    test_random_phase(44, $urandom_range(2, 32'h7fff_ffff), 1'b0);

    wait_until_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_powers.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", expected_powers.size()));
    end
    if (failure_count == 0) begin
      $display("modular_exponentiation verification clean");
    end else begin
      $display("modular_exponentiation verification failed");
    end
    $finish;
  end

endmodule

>>> modular_exponentiation.f
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation.sv
test/modular_exponentiation_test.sv
